[design/dssm_pkg.sv]
// Package for the dual-stack shared-memory core.
// Holds the sizes, the operation and status codes, and the controller command type.
// No dependencies.
package dssm_pkg;

    localparam int DEPTH   = 128;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int CAP_W   = 8;
    localparam int CMP_W   = (CAP_W > CNT_W) ? CAP_W : CNT_W;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(128);

    localparam logic [1:0] MODE_PUSH = 2'd0;
    localparam logic [1:0] MODE_POP  = 2'd1;
    localparam logic [1:0] MODE_PEEK = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic exec;      // transaction accepted: update counts, start store access
        logic load_out;  // move finished result into output register
    } ctrl_cmd_t;

endpackage

[design/dssm_if.sv]
// Channel interfaces of the dual-stack shared-memory core.
// Depends on dssm_pkg for the field widths.
interface dssm_in_if;
    import dssm_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [1:0]               mode;
    logic                     stack_select;
    logic signed [DATA_W-1:0] item_value;

    modport source (output valid, output mode, output stack_select, output item_value,
                    input ready);
    modport sink (input valid, input mode, input stack_select, input item_value,
                  output ready);
endinterface

interface dssm_out_if;
    import dssm_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] data_out;
    logic [1:0]               status;

    modport source (output valid, output data_out, output status, input ready);
    modport sink (input valid, input data_out, input status, output ready);
endinterface

[design/dssm_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module dssm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/dssm_ctrl.sv]
// Controller of the dual-stack shared-memory core: handshakes and sequencing.
// Depends on dssm_pkg.
module dssm_ctrl
    import dssm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output ctrl_cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_FINISH = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        in_ready     = (state_reg == S_IDLE);
        cmd.exec     = in_valid && in_ready;
        cmd.load_out = (state_reg == S_FINISH) && (!out_valid_reg || out_ready);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.exec)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (cmd.load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_exec_to_finish: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> (state_reg == S_FINISH))
        else $error("accepted transaction did not move to finish");

    a_finish_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && out_valid_reg && !out_ready) |=> (state_reg == S_FINISH))
        else $error("result dropped while output register was occupied");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid_reg)
        else $error("loaded result not presented");

endmodule

[design/dssm_dp.sv]
// Datapath of the dual-stack shared-memory core: counts, capacity, store, output register.
// Depends on dssm_pkg and dssm_ram.
module dssm_dp
    import dssm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  ctrl_cmd_t                cmd,
    input  logic                     cfg_we,
    input  logic [CAP_W-1:0]         cfg_wdata,
    input  logic [1:0]               mode,
    input  logic                     stack_select,
    input  logic signed [DATA_W-1:0] item_value,
    output logic signed [DATA_W-1:0] data_out,
    output logic [1:0]               status
);

    logic [CAP_W-1:0]  capacity_reg;
    logic [CNT_W-1:0]  count_low_reg, count_low_next;
    logic [CNT_W-1:0]  count_high_reg, count_high_next;
    logic [1:0]        res_status_reg, res_status_next;
    logic              res_read_reg, res_read_next;
    logic [DATA_W-1:0] data_out_reg;
    logic [1:0]        status_out_reg;

    logic [CMP_W-1:0]  cap_wide;
    logic [CNT_W-1:0]  eff_cap;
    logic [CNT_W:0]    used;
    logic              full;
    logic [CNT_W-1:0]  sel_count;
    logic [CNT_W:0]    high_top;
    logic [CNT_W-1:0]  high_push;
    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    always_comb
    begin
        cap_wide  = CMP_W'(capacity_reg);
        eff_cap   = (cap_wide > CMP_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(cap_wide);
        used      = {1'b0, count_low_reg} + {1'b0, count_high_reg};
        full      = (used >= {1'b0, eff_cap});
        sel_count = stack_select ? count_high_reg : count_low_reg;
        high_push = eff_cap - CNT_W'(1) - count_high_reg;
        // top of the downward stack, wrapped into the store
        high_top  = {1'b0, eff_cap} - {1'b0, count_high_reg};
        if (high_top[CNT_W])
        begin
            high_top = high_top + (CNT_W + 1)'(DEPTH);
        end
        else if (high_top >= (CNT_W + 1)'(DEPTH))
        begin
            high_top = high_top - (CNT_W + 1)'(DEPTH);
        end
    end

    always_comb
    begin
        count_low_next  = count_low_reg;
        count_high_next = count_high_reg;
        res_status_next = res_status_reg;
        res_read_next   = res_read_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_waddr       = stack_select ? ADDR_W'(high_push) : ADDR_W'(count_low_reg);
        ram_raddr       = stack_select ? ADDR_W'(high_top)
                                       : ADDR_W'(count_low_reg - CNT_W'(1));
        if (cmd.exec)
        begin
            res_status_next = ST_OK;
            res_read_next   = 1'b0;
            case (mode)
                MODE_PUSH:
                begin
                    if (full)
                    begin
                        res_status_next = ST_FULL;
                    end
                    else
                    begin
                        ram_we = 1'b1;
                        if (stack_select)
                        begin
                            count_high_next = count_high_reg + CNT_W'(1);
                        end
                        else
                        begin
                            count_low_next = count_low_reg + CNT_W'(1);
                        end
                    end
                end
                MODE_POP, MODE_PEEK:
                begin
                    if (sel_count == '0)
                    begin
                        res_status_next = ST_EMPTY;
                    end
                    else
                    begin
                        ram_re        = 1'b1;
                        res_read_next = 1'b1;
                        if (mode == MODE_POP)
                        begin
                            if (stack_select)
                            begin
                                count_high_next = count_high_reg - CNT_W'(1);
                            end
                            else
                            begin
                                count_low_next = count_low_reg - CNT_W'(1);
                            end
                        end
                    end
                end
                default:
                begin
                    res_status_next = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg   <= CAP_RESET;
            count_low_reg  <= '0;
            count_high_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end
            count_low_reg  <= count_low_next;
            count_high_reg <= count_high_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_status_reg <= res_status_next;
        res_read_reg   <= res_read_next;
        if (cmd.load_out)
        begin
            data_out_reg   <= res_read_reg ? ram_rdata : '0;
            status_out_reg <= res_status_reg;
        end
    end

    dssm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (item_value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign data_out = data_out_reg;
    assign status   = status_out_reg;

    a_counts_fit: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, count_low_reg} + {1'b0, count_high_reg}) <= (CNT_W + 1)'(DEPTH))
        else $error("stack counts exceed store depth");

endmodule

[design/dual_stack_shared_memory_core.sv]
// Dual-stack shared-memory core: two LIFO stacks in one 128-entry store.
// Stack 0 grows up from entry 0, stack 1 grows down from entry capacity-1.
// Channels: in_ch (sink) takes mode (0 push, 1 pop, 2 peek), stack_select and
// item_value; out_ch (source) returns data_out and status (0 ok, 1 full, 2 empty).
// Both are valid/ready; a transaction moves at a clock edge with valid and ready high.
// Capacity is set through cfg_we/cfg_wdata, by the user only while both stacks are
// empty; the block itself does not enforce this. Every transaction gives exactly one
// result, with data_out zero unless a pop or peek succeeds. Capacity values above the
// store depth act as the depth. A result waits for the registered read port of the
// store, then moves into the output register when that register is empty or its
// result is taken. No new transaction is taken before that move. A new transaction
// is taken while the previous result still sits in the output register; if that
// result is not taken, the next one waits and in_ch.ready stays low.
// Reset (rst_n, asynchronous, active low) empties both stacks and sets capacity to
// 128; store contents are not cleared and no clearing pass runs.
// Depends on dssm_pkg, dssm_if, dssm_ctrl, dssm_dp, dssm_ram.
module dual_stack_shared_memory_core
    import dssm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    dssm_in_if.sink          in_ch,
    dssm_out_if.source       out_ch,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata
);

    ctrl_cmd_t cmd;

    dssm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd)
    );

    dssm_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .mode         (in_ch.mode),
        .stack_select (in_ch.stack_select),
        .item_value   (in_ch.item_value),
        .data_out     (out_ch.data_out),
        .status       (out_ch.status)
    );

endmodule

[verif/dual_stack_shared_memory_core_test.sv]
`timescale 1ns / 1ps
// Testbench for dual_stack_shared_memory_core: random push/pop/peek traffic over several
// capacity settings, checked against a built-in stack predictor in a scoreboard class.
// Depends on dssm_pkg, dssm_if and the core RTL.
module dual_stack_shared_memory_core_test;
    import dssm_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int         NUM_PHASES  = 12;

    typedef struct {
        logic signed [DATA_W-1:0] data;
        logic [1:0]               status;
    } stack_result_t;

    class stack_scoreboard;
        logic [DATA_W-1:0] mem [DEPTH];
        int unsigned       cnt_low;
        int unsigned       cnt_high;
        logic [CAP_W-1:0]  capacity;
        stack_result_t     expected_q[$];
        int                errors;
        int                results_seen;

        function new();
            foreach (mem[i])
                mem[i] = '0;
            cnt_low      = 0;
            cnt_high     = 0;
            capacity     = CAP_RESET;
            errors       = 0;
            results_seen = 0;
        endfunction

        function void set_capacity(logic [CAP_W-1:0] value);
            capacity = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Work out the result of one accepted transaction and queue it.
        function void note_input(logic [1:0] mode, logic sel, logic [DATA_W-1:0] value);
            stack_result_t r;
            int unsigned   cap;
            int unsigned   addr;
            int unsigned   cnt;
            cap = (capacity > DEPTH) ? DEPTH : capacity;
            r.data   = '0;
            r.status = ST_OK;
            case (mode)
                MODE_PUSH:
                begin
                    if (cnt_low + cnt_high >= cap)
                        r.status = ST_FULL;
                    else if (!sel)
                    begin
                        mem[cnt_low % DEPTH] = value;
                        cnt_low++;
                    end
                    else
                    begin
                        mem[(cap - 1 - cnt_high) % DEPTH] = value;
                        cnt_high++;
                    end
                end
                MODE_POP, MODE_PEEK:
                begin
                    cnt = sel ? cnt_high : cnt_low;
                    if (cnt == 0)
                        r.status = ST_EMPTY;
                    else
                    begin
                        // stack 1 top is addressed from the current capacity down
                        addr = sel ? (cap + DEPTH - cnt_high) % DEPTH : (cnt_low - 1) % DEPTH;
                        r.data = mem[addr];
                        if (mode == MODE_POP)
                        begin
                            if (sel)
                                cnt_high--;
                            else
                                cnt_low--;
                        end
                    end
                end
                default:
                begin
                end
            endcase
            expected_q.push_back(r);
        endfunction

        function void check_result(logic signed [DATA_W-1:0] data, logic [1:0] status);
            stack_result_t e;
            results_seen++;
            if (expected_q.size() == 0)
            begin
                $error("result with no transaction pending: data_out %0d status %0d",
                       data, status);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (data !== e.data)
            begin
                $error("data_out mismatch: expected %0d, actual %0d", e.data, data);
                errors++;
            end
            if (status !== e.status)
            begin
                $error("status mismatch: expected %0d, actual %0d", e.status, status);
                errors++;
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CAP_W-1:0] cfg_wdata;
    bit               send_gaps;
    bit               recv_stalls;

    stack_scoreboard sb = new();

    dssm_in_if  in_ch();
    dssm_out_if out_ch();

    dual_stack_shared_memory_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Monitor: everything is sampled at the edge, before the block's updates land.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                sb.set_capacity(cfg_wdata);
            if (in_ch.valid && in_ch.ready)
                sb.note_input(in_ch.mode, in_ch.stack_select, in_ch.item_value);
            if (out_ch.valid && out_ch.ready)
                sb.check_result(out_ch.data_out, out_ch.status);
        end
    end

    initial
    begin : result_sink
        int unsigned n;
        bit          held;
        held = 1'b0;
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (!held && sb.results_seen >= 200 && in_ch.valid)
            begin
                // long hold-off so the core fills up and stalls its input
                held = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (60) @(posedge clk);
                out_ch.ready <= 1'b1;
            end
            else if (recv_stalls && $urandom_range(0, 4) == 0)
            begin
                out_ch.ready <= 1'b0;
                n = $urandom_range(1, 13);
                repeat (n) @(posedge clk);
                out_ch.ready <= 1'b1;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // Offer one transaction and return at the edge where it is taken.
    task automatic send_op(logic [1:0] mode, logic sel, logic [DATA_W-1:0] value);
        int unsigned gap;
        if (send_gaps && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 13);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.mode         <= mode;
        in_ch.stack_select <= sel;
        in_ch.item_value   <= value;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Pop stack 1 empty, and stack 0 too unless its data is to be kept.
    task automatic drain(bit both);
        int unsigned n0;
        int unsigned n1;
        n0 = sb.cnt_low;
        n1 = sb.cnt_high;
        repeat (n1) send_op(MODE_POP, 1'b1, $urandom);
        if (both)
            repeat (n0) send_op(MODE_POP, 1'b0, $urandom);
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_op(int unsigned push_pct);
        int unsigned r;
        logic [1:0]  mode;
        r = $urandom_range(0, 99);
        if (r < 3)
            mode = MODE_UNUSED;
        else if (r < push_pct)
            mode = MODE_PUSH;
        else if ($urandom_range(0, 9) < 7)
            mode = MODE_POP;
        else
            mode = MODE_PEEK;
        send_op(mode, 1'($urandom_range(0, 1)), pick_value());
    endtask

    initial
    begin : stimulus
        int unsigned new_cap;
        int unsigned push_pct;
        int unsigned n_items;
        bit          keep_low;

        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = '0;
        in_ch.valid        = 1'b0;
        in_ch.mode         = MODE_PUSH;
        in_ch.stack_select = 1'b0;
        in_ch.item_value   = '0;
        send_gaps          = 1'b1;
        recv_stalls        = 1'b1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty stacks, unused mode, value extremes, both stacks
        send_op(MODE_POP, 1'b0, 32'h0);
        send_op(MODE_PEEK, 1'b1, 32'h0);
        send_op(MODE_UNUSED, 1'b0, 32'hFFFF_FFFF);
        send_op(MODE_PUSH, 1'b0, 32'h7FFF_FFFF);
        send_op(MODE_PUSH, 1'b0, 32'h8000_0000);
        send_op(MODE_PUSH, 1'b1, 32'h0000_0000);
        send_op(MODE_PUSH, 1'b1, 32'hFFFF_FFFF);
        send_op(MODE_PEEK, 1'b0, 32'h0);
        send_op(MODE_POP, 1'b0, 32'h0);
        send_op(MODE_POP, 1'b0, 32'h0);
        send_op(MODE_PEEK, 1'b1, 32'h0);
        send_op(MODE_POP, 1'b1, 32'h0);
        send_op(MODE_POP, 1'b1, 32'h0);
        send_op(MODE_POP, 1'b1, 32'h0);
        send_op(MODE_UNUSED, 1'b1, 32'h5A5A_A5A5);

        // single-entry store: whichever stack takes it, the other sees full
        wait_idle();
        write_capacity(CAP_W'(1));
        send_op(MODE_PUSH, 1'b1, 32'h1234_5678);
        send_op(MODE_PUSH, 1'b0, 32'h1);
        send_op(MODE_PEEK, 1'b1, 32'h0);
        send_op(MODE_POP, 1'b1, 32'h0);
        send_op(MODE_PUSH, 1'b0, 32'h8765_4321);
        send_op(MODE_PUSH, 1'b1, 32'h2);
        send_op(MODE_POP, 1'b0, 32'h0);

        // no room at all
        wait_idle();
        write_capacity(CAP_W'(0));
        send_op(MODE_PUSH, 1'b0, 32'h3);
        send_op(MODE_PUSH, 1'b1, 32'h4);
        send_op(MODE_POP, 1'b0, 32'h0);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_idle();
            // a capacity change with stack 0 still holding data, on a couple of phases
            keep_low = (p == 5 || p == 8);
            drain(!keep_low);
            wait_idle();
            case (p)
                0:       new_cap = 128;
                1:       new_cap = 255;
                2:       new_cap = 2;
                3:       new_cap = 1;
                4:       new_cap = 0;
                5:       new_cap = 40;
                6:       new_cap = 129;
                7:       new_cap = 200;
                8:       new_cap = $urandom_range(1, 128);
                9:       new_cap = $urandom_range(0, 255);
                10:      new_cap = 128;
                default: new_cap = $urandom_range(3, 128);
            endcase
            write_capacity(CAP_W'(new_cap));
            push_pct    = (p == 0 || p == 10) ? 90 : $urandom_range(40, 90);
            n_items     = (p == 4) ? 30 : 90;
            send_gaps   = (p < 10) && ($urandom_range(0, 3) != 0);
            recv_stalls = (p < 10) && ($urandom_range(0, 3) != 0);
            repeat (n_items) random_op(push_pct);
        end

        wait_idle();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[dual_stack_shared_memory_core.f]
design/dssm_pkg.sv
design/dssm_if.sv
design/dssm_ram.sv
design/dssm_ctrl.sv
design/dssm_dp.sv
design/dual_stack_shared_memory_core.sv
verif/dual_stack_shared_memory_core_test.sv
